/* design/ftrb_pkg.sv */
package ftrb_pkg;

   // Buffer geometry.
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths.
   localparam int OPCODE_W  = 2;
   localparam int LEVEL_W   = 3;
   localparam int DOMAIN_W  = 16;
   localparam int MESSAGE_W = 32;
   localparam int WANT_W    = 7;
   localparam int POS_W     = 6;
   localparam int IN_DATA_W  = 64;
   localparam int OUT_DATA_W = 64;

   // Operation codes carried in the request tuser.
   localparam logic [OPCODE_W-1:0] OP_RECORD = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   // One stored trace entry.
   typedef struct packed {
      logic [LEVEL_W-1:0]   level;
      logic [DOMAIN_W-1:0]  domain;
      logic [MESSAGE_W-1:0] message;
   } entry_type;

   // Memory write request.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } mem_wr_type;

   // Memory read request.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   // Query start command from the front end to the scanner.
   typedef struct packed {
      logic               start;
      logic [CNT_W-1:0]   want;
      logic [LEVEL_W-1:0] floor_lvl;
      logic [ADDR_W-1:0]  slot;
      logic [CNT_W-1:0]   live;
   } qry_cmd_type;

   // Scanner states.
   typedef enum logic [3:0] {
      Q_IDLE  = 4'b0001,
      Q_READ  = 4'b0010,
      Q_EVAL  = 4'b0100,
      Q_FLUSH = 4'b1000
   } qry_state_type;

endpackage

/* design/ftrb_mem.sv */
module ftrb_mem (
   input  logic                 clock,
   input  ftrb_pkg::mem_wr_type wr,
   input  ftrb_pkg::mem_rd_type rd,
   output ftrb_pkg::entry_type  rd_data
);

   ftrb_pkg::entry_type mem [ftrb_pkg::DEPTH];
   ftrb_pkg::entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ftrb_query.sv */
module ftrb_query (
   input  logic                         clock,
   input  logic                         reset,
   input  ftrb_pkg::qry_cmd_type        cmd,
   output logic                         busy,
   output ftrb_pkg::mem_rd_type         rd,
   input  ftrb_pkg::entry_type          rd_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ftrb_pkg::entry_type          out_entry,
   output logic [ftrb_pkg::POS_W-1:0]   out_pos,
   output logic                         out_last,
   output logic                         out_none
);

   ftrb_pkg::qry_state_type state_ff, state_in;
   logic [ftrb_pkg::ADDR_W-1:0]  idx_ff, idx_in, idx_prev;
   logic [ftrb_pkg::CNT_W-1:0]   scanned_ff, scanned_in;
   logic [ftrb_pkg::CNT_W-1:0]   written_ff, written_in;
   logic [ftrb_pkg::CNT_W-1:0]   want_ff, want_in;
   logic [ftrb_pkg::CNT_W-1:0]   live_ff, live_in;
   logic [ftrb_pkg::LEVEL_W-1:0] floor_ff, floor_in;

   // A match is held back until the next match or the end of the scan, so that its last flag is known when it leaves.
   logic                         hold_valid_ff, hold_valid_in;
   ftrb_pkg::entry_type          hold_entry_ff, hold_entry_in;
   logic [ftrb_pkg::POS_W-1:0]   hold_pos_ff, hold_pos_in;

   // Output register.
   logic                         out_valid_ff, out_valid_in;
   ftrb_pkg::entry_type          out_entry_ff, out_entry_in;
   logic [ftrb_pkg::POS_W-1:0]   out_pos_ff, out_pos_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_none_ff, out_none_in;

   logic out_free;
   logic match;
   logic done;
   logic push;
   logic push_last;
   logic push_none;

   assign out_free = !out_valid_ff || out_ready;
   assign match    = rd_data.level >= floor_ff;
   assign idx_prev = (idx_ff == '0) ? ftrb_pkg::ADDR_W'(ftrb_pkg::DEPTH - 1)
                                    : idx_ff - 1'b1;
   assign busy     = state_ff != ftrb_pkg::Q_IDLE;

   // Scan sequencer: read one entry, then evaluate it.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      scanned_in    = scanned_ff;
      written_in    = written_ff;
      want_in       = want_ff;
      live_in       = live_ff;
      floor_in      = floor_ff;
      hold_valid_in = hold_valid_ff;
      hold_entry_in = hold_entry_ff;
      hold_pos_in   = hold_pos_ff;
      rd.en         = 1'b0;
      rd.addr       = idx_prev;
      push          = 1'b0;
      push_last     = 1'b0;
      push_none     = 1'b0;
      done          = 1'b0;
      case (state_ff)
         ftrb_pkg::Q_IDLE: begin
            if (cmd.start) begin
               idx_in        = cmd.slot;
               scanned_in    = '0;
               written_in    = '0;
               want_in       = cmd.want;
               live_in       = cmd.live;
               floor_in      = cmd.floor_lvl;
               hold_valid_in = 1'b0;
               state_in      = (cmd.want == '0) ? ftrb_pkg::Q_FLUSH : ftrb_pkg::Q_READ;
            end
         end
         ftrb_pkg::Q_READ: begin
            rd.en      = 1'b1;
            idx_in     = idx_prev;
            scanned_in = scanned_ff + 1'b1;
            state_in   = ftrb_pkg::Q_EVAL;
         end
         ftrb_pkg::Q_EVAL: begin
            // Stall only when a held match must leave and the output is full.
            if (!(match && hold_valid_ff && !out_free)) begin
               if (match) begin
                  push          = hold_valid_ff;
                  hold_valid_in = 1'b1;
                  hold_entry_in = rd_data;
                  hold_pos_in   = ftrb_pkg::POS_W'(written_ff);
                  written_in    = written_ff + 1'b1;
               end
               done     = (written_in == want_ff) || (scanned_ff == live_ff);
               state_in = done ? ftrb_pkg::Q_FLUSH : ftrb_pkg::Q_READ;
            end
         end
         ftrb_pkg::Q_FLUSH: begin
            // Final item of the run: the held match, or the empty answer.
            if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               push_none     = !hold_valid_ff;
               hold_valid_in = 1'b0;
               state_in      = ftrb_pkg::Q_IDLE;
            end
         end
         default: begin
            state_in = ftrb_pkg::Q_IDLE;
         end
      endcase
   end

   // Output register load and drain.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_entry_in = out_entry_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_none_in  = out_none_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_entry_in = push_none ? '0 : hold_entry_ff;
         out_pos_in   = push_none ? '0 : hold_pos_ff;
         out_last_in  = push_last;
         out_none_in  = push_none;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ftrb_pkg::Q_IDLE;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Counters and payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      scanned_ff    <= scanned_in;
      written_ff    <= written_in;
      want_ff       <= want_in;
      live_ff       <= live_in;
      floor_ff      <= floor_in;
      hold_entry_ff <= hold_entry_in;
      hold_pos_ff   <= hold_pos_in;
      out_entry_ff  <= out_entry_in;
      out_pos_ff    <= out_pos_in;
      out_last_ff   <= out_last_in;
      out_none_ff   <= out_none_in;
   end

   assign out_valid = out_valid_ff;
   assign out_entry = out_entry_ff;
   assign out_pos   = out_pos_ff;
   assign out_last  = out_last_ff;
   assign out_none  = out_none_ff;

   // The scan never looks past the live entries.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ftrb_pkg::Q_IDLE) |-> (scanned_ff <= live_ff))
      else $error("scan passed the live entries");

   // A run never returns more items than requested.
   a_written_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ftrb_pkg::Q_IDLE) |-> (written_ff <= want_ff))
      else $error("run returned more items than requested");

   // Evaluation always follows a memory read.
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ftrb_pkg::Q_EVAL) |->
      $past(state_ff == ftrb_pkg::Q_READ || state_ff == ftrb_pkg::Q_EVAL))
      else $error("evaluation without a read");

   // An empty answer always closes its run.
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_none_ff) |-> out_last_ff)
      else $error("empty answer not marked last");

endmodule

/* design/filtered_trace_ring_buffer.sv */
// Overwriting trace buffer of 64 entries with a filtered, newest-first readback.
// Request channel (req_*): tuser carries the operation (record, query, clear),
// tdata the entry fields and the query arguments. Response channel (rsp_*):
// one item per returned entry, newest first; tlast marks the end of a query
// run and tuser flags the single empty answer of a query that matched nothing.
// Record and clear items are taken one per cycle while no query is running and produce no response.
// A query holds off the request channel until its run is complete: it starts,
// then examines each entry with one read of the entry memory's single read port
// and a test of the level, and then closes the run with a final item; response
// stalls lengthen the run.
// A match is held until the next match, or the end of the scan, decides its
// tlast; it then passes through the output register, so its item comes later
// when matches are sparse.
// A stalled response channel stops the scan at the next match; nothing is lost.
// Reset empties the buffer (write slot and live count to zero) and drops any
// query in flight; the entry memory itself is not cleared.
module filtered_trace_ring_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // new_level[2:0], new_domain[18:3], new_message[50:19], want_count[57:51],
   // floor_level[60:58], zero fill above
   input  logic [ftrb_pkg::IN_DATA_W-1:0]      req_tdata,
   // opcode[1:0]
   input  logic [ftrb_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found_level[2:0], found_domain[18:3], found_message[50:19],
   // run_position[56:51], zero fill above
   output logic [ftrb_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   // last_of_run
   output logic                                rsp_tlast,
   // nothing_found[0]
   output logic                                rsp_tuser
);

   logic                           accept;
   logic                           busy;
   logic [ftrb_pkg::LEVEL_W-1:0]   new_level;
   logic [ftrb_pkg::DOMAIN_W-1:0]  new_domain;
   logic [ftrb_pkg::MESSAGE_W-1:0] new_message;
   logic [ftrb_pkg::WANT_W-1:0]    want_count;
   logic [ftrb_pkg::LEVEL_W-1:0]   floor_level;

   logic [ftrb_pkg::ADDR_W-1:0] write_slot_ff, write_slot_in;
   logic [ftrb_pkg::CNT_W-1:0]  live_count_ff, live_count_in;

   ftrb_pkg::mem_wr_type  mem_wr;
   ftrb_pkg::mem_rd_type  mem_rd;
   ftrb_pkg::entry_type   mem_rd_data;
   ftrb_pkg::qry_cmd_type qry_cmd;

   ftrb_pkg::entry_type         out_entry;
   logic [ftrb_pkg::POS_W-1:0]  out_pos;

   // Request unpacking.
   assign new_level   = req_tdata[2:0];
   assign new_domain  = req_tdata[18:3];
   assign new_message = req_tdata[50:19];
   assign want_count  = req_tdata[57:51];
   assign floor_level = req_tdata[60:58];

   // Records never overlap a scan, so memory reads and writes cannot collide.
   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   // Record and clear handling of the slot and the live count.
   always_comb begin
      write_slot_in       = write_slot_ff;
      live_count_in       = live_count_ff;
      mem_wr.en           = 1'b0;
      mem_wr.addr         = write_slot_ff;
      mem_wr.data.level   = new_level;
      mem_wr.data.domain  = new_domain;
      mem_wr.data.message = new_message;
      if (accept) begin
         case (req_tuser)
            ftrb_pkg::OP_RECORD: begin
               mem_wr.en     = 1'b1;
               write_slot_in = (write_slot_ff == ftrb_pkg::ADDR_W'(ftrb_pkg::DEPTH - 1))
                               ? '0 : write_slot_ff + 1'b1;
               if (live_count_ff != ftrb_pkg::CNT_W'(ftrb_pkg::DEPTH)) begin
                  live_count_in = live_count_ff + 1'b1;
               end
            end
            ftrb_pkg::OP_CLEAR: begin
               write_slot_in = '0;
               live_count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Query command; the request is clipped to the live count.
   always_comb begin
      qry_cmd.start     = accept && (req_tuser == ftrb_pkg::OP_QUERY);
      qry_cmd.want      = (want_count > ftrb_pkg::WANT_W'(live_count_ff))
                          ? live_count_ff : ftrb_pkg::CNT_W'(want_count);
      qry_cmd.floor_lvl = floor_level;
      qry_cmd.slot      = write_slot_ff;
      qry_cmd.live      = live_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         live_count_ff <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         live_count_ff <= live_count_in;
      end
   end

   ftrb_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

   ftrb_query u_query (
      .clock     (clock),
      .reset     (reset),
      .cmd       (qry_cmd),
      .busy      (busy),
      .rd        (mem_rd),
      .rd_data   (mem_rd_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (out_entry),
      .out_pos   (out_pos),
      .out_last  (rsp_tlast),
      .out_none  (rsp_tuser)
   );

   // Response packing.
   assign rsp_tdata = {7'd0, out_pos, out_entry.message, out_entry.domain, out_entry.level};

endmodule

/* verif/testbench.sv */
module testbench;

   localparam int IDLE_LIMIT   = 3000;
   localparam int TAIL_CYCLES  = 2 * ftrb_pkg::DEPTH + 20;
   localparam int RANDOM_ITEMS = 240;
   localparam int NO_CLEAR_SPAN = 120;
   localparam int REPORT_LIMIT = 10;

   // Opcode that the block must ignore.
   localparam logic [ftrb_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // One returned entry as seen on the response channel.
   typedef struct packed {
      logic [ftrb_pkg::LEVEL_W-1:0]   level;
      logic [ftrb_pkg::DOMAIN_W-1:0]  domain;
      logic [ftrb_pkg::MESSAGE_W-1:0] message;
      logic [ftrb_pkg::POS_W-1:0]     position;
      logic                           last_of_run;
      logic                           nothing_found;
   } trace_result_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC
   } ready_mode_type;

   // Tracks the ring contents and the queue of responses that queries must return.
   class trace_scoreboard;
      ftrb_pkg::entry_type ring[ftrb_pkg::DEPTH];
      int unsigned         next_slot;
      int unsigned         live_entries;
      trace_result_type    expected_results[$];
      int                  mismatch_count;

      function new();
         next_slot      = 0;
         live_entries   = 0;
         mismatch_count = 0;
      endfunction

      function int pending_results();
         return expected_results.size();
      endfunction

      function string describe(trace_result_type r);
         return $sformatf("level %0d domain %h message %h position %0d last %0b empty %0b",
                          r.level, r.domain, r.message, r.position, r.last_of_run,
                          r.nothing_found);
      endfunction

      // Update the ring for an accepted request and queue the responses of a query.
      function void note_request(logic [ftrb_pkg::OPCODE_W-1:0] op,
                                 logic [ftrb_pkg::IN_DATA_W-1:0] data);
         ftrb_pkg::entry_type          e;
         trace_result_type             run[$];
         trace_result_type             r;
         int unsigned                  want;
         int unsigned                  idx;
         int unsigned                  scanned;
         logic [ftrb_pkg::LEVEL_W-1:0] floor_lvl;
         e.level   = data[2:0];
         e.domain  = data[18:3];
         e.message = data[50:19];
         want      = {25'd0, data[57:51]};
         floor_lvl = data[60:58];
         case (op)
            ftrb_pkg::OP_RECORD: begin
               ring[next_slot] = e;
               next_slot = (next_slot + 1) % ftrb_pkg::DEPTH;
               if (live_entries < ftrb_pkg::DEPTH) live_entries++;
            end
            ftrb_pkg::OP_CLEAR: begin
               next_slot    = 0;
               live_entries = 0;
            end
            ftrb_pkg::OP_QUERY: begin
               // The live count never exceeds the depth, so this also saturates oversized requests.
               if (want > live_entries) want = live_entries;
               idx = next_slot;
               for (scanned = 0; scanned < live_entries && run.size() < want; scanned++) begin
                  idx = (idx + ftrb_pkg::DEPTH - 1) % ftrb_pkg::DEPTH;
                  if (ring[idx].level >= floor_lvl) begin
                     r.level         = ring[idx].level;
                     r.domain        = ring[idx].domain;
                     r.message       = ring[idx].message;
                     r.position      = ftrb_pkg::POS_W'(run.size());
                     r.last_of_run   = 1'b0;
                     r.nothing_found = 1'b0;
                     run.push_back(r);
                  end
               end
               if (run.size() == 0) begin
                  r               = '0;
                  r.last_of_run   = 1'b1;
                  r.nothing_found = 1'b1;
                  run.push_back(r);
               end else begin
                  run[run.size() - 1].last_of_run = 1'b1;
               end
               foreach (run[i]) expected_results.push_back(run[i]);
            end
            default: begin
            end
         endcase
      endfunction

      // Compare one accepted response with the oldest expected one.
      function void check_response(logic [ftrb_pkg::OUT_DATA_W-1:0] data, logic tlast,
                                   logic tuser);
         trace_result_type got;
         trace_result_type want_r;
         got.level         = data[2:0];
         got.domain        = data[18:3];
         got.message       = data[50:19];
         got.position      = data[56:51];
         got.last_of_run   = tlast;
         got.nothing_found = tuser;
         if (expected_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("Unexpected response at %0t: %s", $time, describe(got));
            mismatch_count++;
            return;
         end
         want_r = expected_results.pop_front();
         if (got.level !== want_r.level || got.domain !== want_r.domain ||
             got.message !== want_r.message || got.position !== want_r.position ||
             got.last_of_run !== want_r.last_of_run ||
             got.nothing_found !== want_r.nothing_found) begin
            if (mismatch_count < REPORT_LIMIT) begin
               $display("Response error at %0t", $time);
               $display("   expected %s", describe(want_r));
               $display("   actual   %s", describe(got));
            end
            mismatch_count++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ftrb_pkg::IN_DATA_W-1:0]  req_tdata = '0;
   logic [ftrb_pkg::OPCODE_W-1:0]   req_tuser = ftrb_pkg::OP_RECORD;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ftrb_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   trace_scoreboard sb = new();
   int              burst_left = 0;
   int              idle_cycles = 0;
   ready_mode_type  ready_mode = READY_ALWAYS;
   int              ready_hold = 0;

   filtered_trace_ring_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // The response side stalls in phases: always ready, random, or a fixed duty pattern.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(2));
         ready_hold <= $urandom_range(16, 96);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= 1'($urandom_range(1));
         default:      rsp_tready <= (ready_hold % 6) >= 2;
      endcase
   end

   // Monitor both channels and stop the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Present one item and hold it until the block takes it; bursts may be separated by gaps.
   task automatic send_item(input logic [ftrb_pkg::OPCODE_W-1:0] op,
                            input logic [ftrb_pkg::LEVEL_W-1:0] level,
                            input logic [ftrb_pkg::DOMAIN_W-1:0] domain,
                            input logic [ftrb_pkg::MESSAGE_W-1:0] message,
                            input logic [ftrb_pkg::WANT_W-1:0] want,
                            input logic [ftrb_pkg::LEVEL_W-1:0] floor_lvl);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? 60 : int'($urandom_range(1, 16));
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, floor_lvl, want, message, domain, level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic record_entry(input logic [ftrb_pkg::LEVEL_W-1:0] level,
                               input logic [ftrb_pkg::DOMAIN_W-1:0] domain,
                               input logic [ftrb_pkg::MESSAGE_W-1:0] message);
      send_item(ftrb_pkg::OP_RECORD, level, domain, message, 7'($urandom), 3'($urandom));
   endtask

   task automatic query_entries(input logic [ftrb_pkg::WANT_W-1:0] want,
                                input logic [ftrb_pkg::LEVEL_W-1:0] floor_lvl);
      send_item(ftrb_pkg::OP_QUERY, 3'($urandom), 16'($urandom), $urandom, want, floor_lvl);
   endtask

   task automatic clear_buffer();
      send_item(ftrb_pkg::OP_CLEAR, 3'($urandom), 16'($urandom), $urandom, 7'($urandom),
                3'($urandom));
   endtask

   // Hold the request side idle until every queued response has arrived.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending_results() != 0) @(posedge clock);
   endtask

   initial begin
      int          counted;
      int          pick;
      logic [6:0]  want;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty buffer, field extremes, filters and ignored opcode.
      query_entries(7'd1, 3'd0);
      record_entry(3'd7, 16'hFFFF, 32'hFFFF_FFFF);
      record_entry(3'd0, 16'h0000, 32'h0000_0000);
      record_entry(3'd3, 16'h1234, $urandom);
      record_entry(3'd5, 16'($urandom), $urandom);
      query_entries(7'd127, 3'd0);
      query_entries(7'd0, 3'd0);
      query_entries(7'd2, 3'd4);
      query_entries(7'd64, 3'd7);
      send_item(OP_UNUSED, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 7'd127, 3'd7);
      query_entries(7'd10, 3'd0);
      clear_buffer();
      query_entries(7'd5, 3'd0);
      record_entry(3'd2, 16'($urandom), $urandom);
      query_entries(7'd4, 3'd3);
      record_entry(3'd6, 16'($urandom), $urandom);
      query_entries(7'd1, 3'd2);
      query_entries(7'd3, 3'd6);

      wait_for_responses();

      // Random part: mostly records with interleaved queries; clears only later so the ring wraps.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = int'($urandom_range(99));
         if (pick < 72) begin
            record_entry(3'($urandom), 16'($urandom), $urandom);
            counted++;
         end else if (pick < 92) begin
            case ($urandom_range(9))
               0:       want = 7'($urandom_range(ftrb_pkg::DEPTH + 1, 127));
               1:       want = 7'($urandom_range(9, ftrb_pkg::DEPTH));
               default: want = 7'($urandom_range(0, 8));
            endcase
            query_entries(want, 3'($urandom_range(7)));
            counted++;
         end else if (pick < 96) begin
            send_item(OP_UNUSED, 3'($urandom), 16'($urandom), $urandom, 7'($urandom),
                      3'($urandom));
         end else if (pick < 98 && counted > NO_CLEAR_SPAN) begin
            clear_buffer();
            counted++;
         end else begin
            record_entry(3'($urandom), 16'($urandom), $urandom);
            counted++;
         end
      end

      wait_for_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending_results() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
design/ftrb_pkg.sv
design/ftrb_mem.sv
design/ftrb_query.sv
design/filtered_trace_ring_buffer.sv
verif/testbench.sv
